// File: rtl/core/feg_pkg.sv
// Shared types, constants and codes for the fade envelope generator.
package feg_pkg;

  localparam int ACCUM_WIDTH = 32;
  localparam int FIELD_W     = 16;
  localparam int PHASE_W     = 3;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [FIELD_W-1:0] FULL_LEVEL = 16'h8000;

  // step * 32768 / len with step < len gives a 15-bit quotient
  localparam int QUO_W      = 15;
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [PHASE_W-1:0] PH_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRIME = 3'd1;
  localparam logic [PHASE_W-1:0] PH_UP    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DOWN  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;

  localparam logic [1:0] REG_RAMP_UP   = 2'd0;
  localparam logic [1:0] REG_HOLD      = 2'd1;
  localparam logic [1:0] REG_RAMP_DOWN = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] ramp_up_ms;
    logic [FIELD_W-1:0] hold_ms;
    logic [FIELD_W-1:0] ramp_down_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

// File: rtl/core/fade_envelope_generator.sv
// Fade envelope generator top level: one pass of prime, ramp up, hold, ramp down, done.
// Each item is registered at accept; on a ramp tick it then passes through the 15-step serial
// divider that forms step * 32768 / ramp length, and the commit state writes the result register.
// One item at a time: the next item is taken only once the previous one has committed, and
// it can be taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low): phase start, accumulator and level zero, registers zero.
module fade_envelope_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [feg_pkg::FIELD_W-1:0]   in_elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [feg_pkg::FIELD_W-1:0]   out_fade_level,
  output logic [feg_pkg::PHASE_W-1:0]   out_phase,
  output logic                          out_level_driven,
  output logic                          out_finished,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [feg_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [feg_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [feg_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import feg_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  feg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  feg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  feg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_elapsed_ms    (in_elapsed_ms),
    .out_fade_level   (out_fade_level),
    .out_phase        (out_phase),
    .out_level_driven (out_level_driven),
    .out_finished     (out_finished)
  );

endmodule

// File: rtl/core/feg_regs.sv
// Configuration register file behind the APB-style port.
module feg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [feg_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [feg_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [feg_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output feg_pkg::cfg_t               cfg
);
  import feg_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RAMP_UP:   cfg_r.ramp_up_ms   <= cfg_pwdata[FIELD_W-1:0];
        REG_HOLD:      cfg_r.hold_ms      <= cfg_pwdata[FIELD_W-1:0];
        REG_RAMP_DOWN: cfg_r.ramp_down_ms <= cfg_pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RAMP_UP:   cfg_prdata = DATA_W'(cfg_r.ramp_up_ms);
      REG_HOLD:      cfg_prdata = DATA_W'(cfg_r.hold_ms);
      REG_RAMP_DOWN: cfg_prdata = DATA_W'(cfg_r.ramp_down_ms);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/feg_dp.sv
// Datapath: envelope phase, step accumulator, level, serial ramp divider, result register.
module feg_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  feg_pkg::cfg_t                 cfg,
  input  feg_pkg::dp_cmd_t              cmd,
  output feg_pkg::dp_status_t           status,
  input  logic [feg_pkg::FIELD_W-1:0]   in_elapsed_ms,
  output logic [feg_pkg::FIELD_W-1:0]   out_fade_level,
  output logic [feg_pkg::PHASE_W-1:0]   out_phase,
  output logic                          out_level_driven,
  output logic                          out_finished
);
  import feg_pkg::*;

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [ACCUM_WIDTH-1:0] accum_r, accum_nxt;
  logic [FIELD_W-1:0]     level_r, level_nxt;
  logic [FIELD_W-1:0]     elapsed_r;

  logic [FIELD_W-1:0]     rem_r, den_r;
  logic [QUO_W-1:0]       quo_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [FIELD_W:0]       rem_shl;
  logic                   rem_ge;

  logic [ACCUM_WIDTH:0]   accum_sum;
  logic [ACCUM_WIDTH-1:0] accum_sat;
  logic                   up_active, hold_active, down_active;
  logic                   driven;

  assign up_active   = (cfg.ramp_up_ms != '0) &&
                       (accum_r < ACCUM_WIDTH'(cfg.ramp_up_ms));
  assign hold_active = accum_r < ACCUM_WIDTH'(cfg.hold_ms);
  assign down_active = (cfg.ramp_down_ms != '0) &&
                       (accum_r < ACCUM_WIDTH'(cfg.ramp_down_ms));

  assign status.need_div = ((phase_r == PH_UP) && up_active) ||
                           ((phase_r == PH_DOWN) && down_active);
  assign status.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  assign accum_sum = {1'b0, accum_r} + (ACCUM_WIDTH + 1)'(elapsed_r);
  assign accum_sat = accum_sum[ACCUM_WIDTH] ? '1 : accum_sum[ACCUM_WIDTH-1:0];

  // restoring division, one quotient bit per step
  assign rem_shl = {rem_r, 1'b0};
  assign rem_ge  = rem_shl >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elapsed_r <= in_elapsed_ms;
      // accumulator is below the ramp length whenever the quotient is used
      rem_r     <= accum_r[FIELD_W-1:0];
      den_r     <= (phase_r == PH_UP) ? cfg.ramp_up_ms : cfg.ramp_down_ms;
      quo_r     <= '0;
      cnt_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? FIELD_W'(rem_shl - {1'b0, den_r}) : rem_shl[FIELD_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], rem_ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    level_nxt = level_r;
    driven    = 1'b0;
    case (phase_r)
      PH_START: begin
        accum_nxt = '0;
        phase_nxt = PH_PRIME;
      end
      PH_PRIME: begin
        if (cfg.ramp_up_ms != '0) begin
          level_nxt = '0;
          driven    = 1'b1;
        end
        accum_nxt = '0;
        phase_nxt = PH_UP;
      end
      PH_UP: begin
        driven = 1'b1;
        if (up_active) begin
          level_nxt = {1'b0, quo_r};
          accum_nxt = accum_sat;
        end else begin
          level_nxt = FULL_LEVEL;
          accum_nxt = '0;
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (hold_active) begin
          accum_nxt = accum_sat;
        end else begin
          accum_nxt = '0;
          phase_nxt = PH_DOWN;
        end
      end
      PH_DOWN: begin
        driven = 1'b1;
        if (down_active) begin
          level_nxt = FULL_LEVEL - {1'b0, quo_r};
          accum_nxt = accum_sat;
        end else begin
          level_nxt = '0;
          accum_nxt = '0;
          phase_nxt = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      accum_r <= '0;
      level_r <= '0;
    end else if (cmd.commit) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_fade_level   <= level_nxt;
      out_phase        <= phase_nxt;
      out_level_driven <= driven;
      out_finished     <= (phase_nxt == PH_DONE);
    end
  end

endmodule

// File: rtl/core/feg_ctrl.sv
// Controller: item handshake, divider sequencing and result register handoff.
module feg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  feg_pkg::dp_status_t  status,
  output feg_pkg::dp_cmd_t     cmd
);
  import feg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CMT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign cmd.load     = accept;
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.commit   = (state_r == S_CMT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= status.need_div ? S_DIV : S_CMT;
          end
        end
        S_DIV: begin
          if (status.div_last) begin
            state_r <= S_CMT;
          end
        end
        S_CMT: begin
          // hold until the result register is free
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/feg_checker.sv
// Port-level checker for the fade envelope generator, bound to the top level.
module feg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [feg_pkg::FIELD_W-1:0]   out_fade_level,
  input logic [feg_pkg::PHASE_W-1:0]   out_phase,
  input logic                          out_level_driven,
  input logic                          out_finished
);
  import feg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fade_level) && $stable(out_phase))
    else $error("result changed while stalled");

  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_finished == (out_phase == PH_DONE)))
    else $error("finished flag disagrees with phase");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fade_level <= FULL_LEVEL)
    else $error("fade level above full scale");

  a_edge_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level_driven |->
      (out_phase != PH_PRIME) &&
      ((out_phase != PH_HOLD) || (out_fade_level == FULL_LEVEL)) &&
      ((out_phase != PH_DONE) || (out_fade_level == '0)))
    else $error("wrong level at phase boundary");

endmodule

bind fade_envelope_generator feg_checker u_feg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_fade_level   (out_fade_level),
  .out_phase        (out_phase),
  .out_level_driven (out_level_driven),
  .out_finished     (out_finished)
);
